/* rtl/sdtm_pkg.sv */
// ----------------------------------------------------------------------------
// sdtm_pkg: shared types and constants of the scored tone mixer
// score geometry, payload structs, state codes and the q1.15 sine table
// ----------------------------------------------------------------------------
`default_nettype none

package sdtm_pkg;

  localparam int TRACKS            = 2;
  localparam int ENTRIES_PER_TRACK = 6;
  localparam int SINE_DEPTH        = 1024;
  localparam int PHASE_BITS        = 24;

  localparam int SCORE_SIZE = TRACKS * ENTRIES_PER_TRACK;
  localparam int TRK_W      = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int ENT_W      = (ENTRIES_PER_TRACK > 1) ? $clog2(ENTRIES_PER_TRACK) : 1;
  localparam int SC_AW      = (SCORE_SIZE > 1) ? $clog2(SCORE_SIZE) : 1;
  localparam int SINE_AW    = $clog2(SINE_DEPTH);
  // sum of level * sine over all tracks, each term below 2^30 in magnitude
  localparam int ACC_W      = 32 + $clog2(TRACKS);

  localparam longint Q30_ONE = 64'sd1073741824;

  // item codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // register indexes
  localparam logic REG_SLOT_LENGTH = 1'b0;
  localparam logic REG_SLOT_COUNT  = 1'b1;

  localparam logic [19:0] SLOT_LENGTH_RST = 20'd19200;
  localparam logic [8:0]  SLOT_COUNT_RST  = 9'd9;

  typedef struct packed {
    logic        action;
    logic [0:0]  track;
    logic [2:0]  entry;
    logic [7:0]  begin_slot;
    logic [7:0]  end_slot;
    logic [23:0] phase_step;
    logic [14:0] level;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [7:0]         slot;
  } out_item_t;

  typedef struct packed {
    logic [7:0]            begin_slot;
    logic [7:0]            end_slot;
    logic [PHASE_BITS-1:0] step;
    logic [14:0]           level;
  } score_word_t;

  typedef struct packed {
    logic [PHASE_BITS-1:0] phase;
    logic [PHASE_BITS-1:0] step;
    logic [14:0]           level;
  } trk_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRD,
    ST_SCHK,
    ST_TRD,
    ST_TPH,
    ST_TMUL,
    ST_TACC,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef logic signed [15:0] sine_tab_t [SINE_DEPTH];

  // odd polynomial on a q30 quarter-turn argument, quadrant symmetry
  function automatic sine_tab_t build_sine_table();
    sine_tab_t       tab;
    longint unsigned turn;
    longint          x;
    longint          x2;
    longint          p;
    longint          s;
    longint          v;
    int unsigned     quad;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      turn = (longint'(k) << 32) / SINE_DEPTH;
      quad = int'((turn >> 30) & 64'd3);
      x    = longint'(turn & 64'h3FFF_FFFF);
      if (quad[0]) begin
        x = Q30_ONE - x;
      end
      x2 = (x * x) / Q30_ONE;
      p  = 172272;
      p  = -5026995 + (p * x2) / Q30_ONE;
      p  = 85569306 + (p * x2) / Q30_ONE;
      p  = -693598668 + (p * x2) / Q30_ONE;
      p  = 1686629713 + (p * x2) / Q30_ONE;
      s  = (x * p) / Q30_ONE;
      if (s < 0) begin
        s = 0;
      end
      v = (s * 32767 + Q30_ONE / 2) / Q30_ONE;
      if (v > 32767) begin
        v = 32767;
      end
      tab[k] = 16'((quad >= 2) ? -v : v);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_ROM = build_sine_table();

endpackage

`default_nettype wire

/* rtl/scored_dds_tone_mixer.sv */
// ----------------------------------------------------------------------------
// scored_dds_tone_mixer: multi-track dds tone sequencer
// score memory, per-track phase memory, shared sine rom, mix and saturate
// ----------------------------------------------------------------------------
// A write item (action 0) stores one score entry; a tick item (action 1)
// produces one signed 16-bit sample and its slot.
// Tracks are handled one at a time through the track-state memory and the
// single sine rom read port: each track passes the read, phase, multiply and
// accumulate steps, then the sum is divided by 32767 and saturated; no new
// item is accepted until the tick finishes. On the first sample of a slot
// the score memory is scanned entry by entry for each track, a read and a
// check per entry, until the first covering entry or the last entry. The
// output register lets the next item be accepted while a sample still waits.
// No clearing pass after reset: entries never written read as their reset
// values through per-entry valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module scored_dds_tone_mixer (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // item input
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire sdtm_pkg::in_item_t   in_item,
  // sample output
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output sdtm_pkg::out_item_t       out_item,
  // register port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int ACC_W = sdtm_pkg::ACC_W;
  localparam int QW    = ACC_W - 15;
  localparam int PB    = sdtm_pkg::PHASE_BITS;

  localparam sdtm_pkg::score_word_t SCORE_RST = '{
    begin_slot: 8'hFF, end_slot: 8'h00, step: '0, level: '0
  };

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [19:0] slot_len_r;
  logic [8:0]  slot_num_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_len_r <= sdtm_pkg::SLOT_LENGTH_RST;
      slot_num_r <= sdtm_pkg::SLOT_COUNT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        sdtm_pkg::REG_SLOT_LENGTH: slot_len_r <= pwdata[19:0];
        sdtm_pkg::REG_SLOT_COUNT:  slot_num_r <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      sdtm_pkg::REG_SLOT_LENGTH: prdata = {12'd0, slot_len_r};
      sdtm_pkg::REG_SLOT_COUNT:  prdata = {23'd0, slot_num_r};
      default:                   prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // control state
  // --------------------------------------------------------------------------
  sdtm_pkg::state_t          state_r;
  sdtm_pkg::state_t          state_nxt;
  logic [sdtm_pkg::TRK_W-1:0] track_r;
  logic [sdtm_pkg::ENT_W-1:0] ent_r;
  logic                      scan_r;      // this tick opens a slot
  logic [7:0]                slot_r;      // slot of the tick in flight
  logic [19:0]               sample_cnt_r;
  logic [7:0]                slot_cnt_r;

  logic in_acc;
  logic tick_acc;
  logic wr_acc;
  logic last_track;
  logic last_entry;
  logic match;
  logic out_free;

  assign in_stall   = (state_r != sdtm_pkg::ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign tick_acc   = in_acc && (in_item.action == sdtm_pkg::ACT_TICK);
  assign wr_acc     = in_acc && (in_item.action == sdtm_pkg::ACT_WRITE);
  assign last_track = (track_r == sdtm_pkg::TRK_W'(sdtm_pkg::TRACKS - 1));
  assign last_entry = (ent_r == sdtm_pkg::ENT_W'(sdtm_pkg::ENTRIES_PER_TRACK - 1));
  assign out_free   = !out_valid || !out_stall;

  // --------------------------------------------------------------------------
  // score memory: one entry per track and entry slot, valid flags give the
  // reset contents (begin all ones, end zero: never matches)
  // --------------------------------------------------------------------------
  sdtm_pkg::score_word_t score_mem [sdtm_pkg::SCORE_SIZE];
  logic [sdtm_pkg::SCORE_SIZE-1:0] score_vld_r;
  sdtm_pkg::score_word_t sc_q_r;
  logic                  sc_vq_r;
  sdtm_pkg::score_word_t sc_rd;
  logic [sdtm_pkg::SC_AW-1:0] sc_raddr;
  logic [sdtm_pkg::SC_AW-1:0] sc_waddr;
  logic                  wr_in_range;

  assign sc_raddr = sdtm_pkg::SC_AW'(int'(track_r) * sdtm_pkg::ENTRIES_PER_TRACK
                                     + int'(ent_r));
  assign sc_waddr = sdtm_pkg::SC_AW'(int'(in_item.track) * sdtm_pkg::ENTRIES_PER_TRACK
                                     + int'(in_item.entry));
  // writes aimed outside the score are dropped
  assign wr_in_range = (int'(in_item.track) < sdtm_pkg::TRACKS) &&
                       (int'(in_item.entry) < sdtm_pkg::ENTRIES_PER_TRACK);

  always_ff @(posedge clk) begin
    if (wr_acc && wr_in_range) begin
      score_mem[sc_waddr] <= '{
        begin_slot: in_item.begin_slot,
        end_slot:   in_item.end_slot,
        step:       PB'(in_item.phase_step),
        level:      in_item.level
      };
    end
    sc_q_r <= score_mem[sc_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_vld_r <= '0;
      sc_vq_r     <= 1'b0;
    end else begin
      if (wr_acc && wr_in_range) begin
        score_vld_r[sc_waddr] <= 1'b1;
      end
      sc_vq_r <= score_vld_r[sc_raddr];
    end
  end

  assign sc_rd = sc_vq_r ? sc_q_r : SCORE_RST;
  assign match = (slot_r >= sc_rd.begin_slot) && (slot_r <= sc_rd.end_slot);

  // --------------------------------------------------------------------------
  // track-state memory: phase accumulator and active tone per track,
  // read at track_r every cycle, written back in the phase step
  // --------------------------------------------------------------------------
  sdtm_pkg::trk_word_t trk_mem [sdtm_pkg::TRACKS];
  logic [sdtm_pkg::TRACKS-1:0] trk_vld_r;
  sdtm_pkg::trk_word_t trk_q_r;
  logic                trk_vq_r;
  sdtm_pkg::trk_word_t trk_rd;
  sdtm_pkg::trk_word_t trk_wr;

  logic [PB-1:0] sel_step_r;
  logic [14:0]   sel_level_r;
  logic [PB-1:0] step_use;
  logic [14:0]   level_use;
  logic [PB-1:0] ph_sum;

  assign trk_rd    = trk_vq_r ? trk_q_r : '0;
  // at a slot start the freshly selected tone replaces the stored one
  assign step_use  = scan_r ? sel_step_r : trk_rd.step;
  assign level_use = scan_r ? sel_level_r : trk_rd.level;
  assign ph_sum    = trk_rd.phase + step_use;
  assign trk_wr    = '{phase: ph_sum, step: step_use, level: level_use};

  always_ff @(posedge clk) begin
    if (state_r == sdtm_pkg::ST_TPH) begin
      trk_mem[track_r] <= trk_wr;
    end
    trk_q_r <= trk_mem[track_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_vld_r <= '0;
      trk_vq_r  <= 1'b0;
    end else begin
      if (state_r == sdtm_pkg::ST_TPH) begin
        trk_vld_r[track_r] <= 1'b1;
      end
      trk_vq_r <= trk_vld_r[track_r];
    end
  end

  // --------------------------------------------------------------------------
  // sine rom, registered read addressed by the top phase bits
  // --------------------------------------------------------------------------
  logic [sdtm_pkg::SINE_AW-1:0] rom_addr;
  logic signed [15:0]           sine_q_r;

  assign rom_addr = ph_sum[PB-1 -: sdtm_pkg::SINE_AW];

  always_ff @(posedge clk) begin
    sine_q_r <= sdtm_pkg::SINE_ROM[rom_addr];
  end

  // --------------------------------------------------------------------------
  // state machine
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdtm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sdtm_pkg::ST_IDLE: begin
        if (tick_acc) begin
          state_nxt = (sample_cnt_r == '0) ? sdtm_pkg::ST_SRD : sdtm_pkg::ST_TRD;
        end
      end
      sdtm_pkg::ST_SRD:  state_nxt = sdtm_pkg::ST_SCHK;
      sdtm_pkg::ST_SCHK: begin
        if (match || last_entry) begin
          state_nxt = sdtm_pkg::ST_TRD;
        end else begin
          state_nxt = sdtm_pkg::ST_SRD;
        end
      end
      sdtm_pkg::ST_TRD:  state_nxt = sdtm_pkg::ST_TPH;
      sdtm_pkg::ST_TPH:  state_nxt = sdtm_pkg::ST_TMUL;
      sdtm_pkg::ST_TMUL: state_nxt = sdtm_pkg::ST_TACC;
      sdtm_pkg::ST_TACC: begin
        if (last_track) begin
          state_nxt = sdtm_pkg::ST_DIV;
        end else begin
          state_nxt = scan_r ? sdtm_pkg::ST_SRD : sdtm_pkg::ST_TRD;
        end
      end
      sdtm_pkg::ST_DIV:  state_nxt = sdtm_pkg::ST_OUT;
      sdtm_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = sdtm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sdtm_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // track and entry pointers, tick context
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r <= '0;
      ent_r   <= '0;
      scan_r  <= 1'b0;
      slot_r  <= '0;
    end else begin
      case (state_r)
        sdtm_pkg::ST_IDLE: begin
          if (tick_acc) begin
            track_r <= '0;
            ent_r   <= '0;
            scan_r  <= (sample_cnt_r == '0);
            slot_r  <= slot_cnt_r;
          end
        end
        sdtm_pkg::ST_SCHK: begin
          if (!match && !last_entry) begin
            ent_r <= ent_r + 1'b1;
          end
        end
        sdtm_pkg::ST_TACC: begin
          ent_r <= '0;
          if (last_track) begin
            track_r <= '0;
          end else begin
            track_r <= track_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // first covering entry wins, silence if the scan runs out
  always_ff @(posedge clk) begin
    if (state_r == sdtm_pkg::ST_SCHK) begin
      if (match) begin
        sel_step_r  <= sc_rd.step;
        sel_level_r <= sc_rd.level;
      end else if (last_entry) begin
        sel_step_r  <= '0;
        sel_level_r <= '0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sample and slot counters, advanced when a tick is taken
  // --------------------------------------------------------------------------
  logic [20:0] samp_inc;
  logic [8:0]  slot_inc;

  assign samp_inc = {1'b0, sample_cnt_r} + 21'd1;
  assign slot_inc = {1'b0, slot_cnt_r} + 9'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_cnt_r <= '0;
      slot_cnt_r   <= '0;
    end else if (tick_acc) begin
      // reached-or-passed compare: a shrunk slot length or count acts at once
      if (samp_inc >= {1'b0, slot_len_r}) begin
        sample_cnt_r <= '0;
        if ((slot_inc >= slot_num_r) || slot_inc[8]) begin
          slot_cnt_r <= '0;
        end else begin
          slot_cnt_r <= slot_inc[7:0];
        end
      end else begin
        sample_cnt_r <= samp_inc[19:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // scale by level and accumulate over tracks
  // --------------------------------------------------------------------------
  logic [14:0]              lvl_r;
  logic signed [31:0]       prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    if (state_r == sdtm_pkg::ST_TPH) begin
      lvl_r <= level_use;
    end
    if (state_r == sdtm_pkg::ST_TMUL) begin
      prod_r <= 32'($signed({1'b0, lvl_r})) * 32'(sine_q_r);
    end
    if (tick_acc) begin
      acc_r <= '0;
    end else if (state_r == sdtm_pkg::ST_TACC) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // --------------------------------------------------------------------------
  // divide by 32767 toward zero: 2^15 = 32767 + 1, so each fold moves the
  // quotient estimate into the remainder; two folds and one compare suffice
  // --------------------------------------------------------------------------
  logic [ACC_W-1:0] mag;
  logic [QW-1:0]    q0;
  logic [QW:0]      r0;
  logic [QW-1:0]    q0_r;
  logic [QW:0]      r0_r;
  logic             neg_r;

  assign mag = acc_r[ACC_W-1] ? $unsigned(-acc_r) : $unsigned(acc_r);
  assign q0  = mag[ACC_W-1:15];
  assign r0  = (QW+1)'(mag[14:0]) + (QW+1)'(q0);

  always_ff @(posedge clk) begin
    if (state_r == sdtm_pkg::ST_DIV) begin
      q0_r  <= q0;
      r0_r  <= r0;
      neg_r <= acc_r[ACC_W-1];
    end
  end

  logic [QW-15:0]   q1;
  logic [15:0]      r1;
  logic [QW-1:0]    quo;
  logic signed [15:0] samp;

  assign q1  = r0_r[QW:15];
  assign r1  = {1'b0, r0_r[14:0]} + 16'(q1);
  assign quo = q0_r + QW'(q1) + QW'(r1 >= 16'd32767);

  // saturate to the signed 16-bit range
  always_comb begin
    if (neg_r) begin
      if (quo >= QW'(32768)) begin
        samp = 16'sh8000;
      end else begin
        samp = -$signed(quo[15:0]);
      end
    end else begin
      if (quo > QW'(32767)) begin
        samp = 16'sh7FFF;
      end else begin
        samp = $signed(quo[15:0]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic                out_valid_r;
  sdtm_pkg::out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == sdtm_pkg::ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sdtm_pkg::ST_OUT && out_free) begin
      out_item_r <= '{sample: samp, slot: slot_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> state_r == sdtm_pkg::ST_IDLE)
    else $error("item taken while a tick is in flight");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sdtm_pkg::ST_SCHK |->
      int'(ent_r) < sdtm_pkg::ENTRIES_PER_TRACK)
    else $error("score scan ran past the last entry");

  a_sample_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sdtm_pkg::ST_OUT && out_free |=>
      out_valid_r && state_r == sdtm_pkg::ST_IDLE)
    else $error("finished sample not presented");

  a_tick_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sdtm_pkg::ST_TACC && last_track |=>
      state_r == sdtm_pkg::ST_DIV && track_r == '0)
    else $error("track loop did not close");

endmodule

`default_nettype wire
